/* src/opp_pkg.sv */
// Package for the octilinear polyline plotter: grid size, index widths,
// opcode and register codes, and the sequencer state type. No dependencies.
`default_nettype none

package opp_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int IDX_W = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int DLT_W = IDX_W + 1;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int COORD_W   = 16;
  localparam int CNT_W     = 16;
  localparam int WORD_W    = 64;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_NEXT  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD,
    ST_WR,
    ST_RDOUT,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

/* src/opp_in_if.sv */
// Command channel of the plotter: valid/ready handshake with opcode and point.
// Depends on opp_pkg for the field widths.
`default_nettype none

interface opp_in_if import opp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic signed [COORD_W-1:0] point_col;
  logic signed [COORD_W-1:0] point_row;

  modport source (output valid, output opcode, output point_col, output point_row,
                  input ready);
  modport sink   (input valid, input opcode, input point_col, input point_row,
                  output ready);
endinterface

`default_nettype wire

/* src/opp_out_if.sv */
// Result channel of the plotter: valid/ready handshake with row word and error record.
// Depends on opp_pkg for the field widths.
`default_nettype none

interface opp_out_if import opp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] row_bits;
  logic              error_seen;
  logic [CNT_W-1:0]  error_line;
  logic [CNT_W-1:0]  error_point;

  modport source (output valid, output row_bits, output error_seen, output error_line,
                  output error_point, input ready);
  modport sink   (input valid, input row_bits, input error_seen, input error_line,
                  input error_point, output ready);
endinterface

`default_nettype wire

/* src/octilinear_polyline_plotter.sv */
// Sequence: start, clear and out-of-range reads go from execute straight to done;
// an in-range read passes through read and readout, a segment through read and write.
// One item is handled at a time; a segment costs one read-modify-write of the grid
// memory per row it spans, a read state followed by a write state.
// Reset (asynchronous, active low) empties the grid at once through per-row valid
// bits, zeroes counters and error record, and sets both size registers to 64.
`default_nettype none

module octilinear_polyline_plotter import opp_pkg::*; (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_W-1:0]      cfg_data_i,
  opp_in_if.sink               in_i,
  opp_out_if.source            out_o
);

  // Sequencer and captured command.
  state_e                    state_q, state_d;
  opcode_e                   op_q;
  logic signed [COORD_W-1:0] row_q, col_q;

  // Size registers.
  logic [CFG_W-1:0] cfg_rows_q, cfg_cols_q;

  // Architectural state of the plotter.
  logic [ROW_W-1:0] last_r_q, last_r_d;
  logic [COL_W-1:0] last_c_q, last_c_d;
  logic [CNT_W-1:0] line_q, line_d, point_q, point_d;
  logic             fault_q, fault_d;
  logic [CNT_W-1:0] fline_q, fline_d, fpoint_q, fpoint_d;

  // Segment walker. The row/column stepper is the one shared unit: each pass
  // through the write state marks one row and, but for the last, moves one step along the segment.
  logic [ROW_W-1:0] cur_r_q, cur_r_d;
  logic [COL_W-1:0] cur_c_q, cur_c_d;
  logic [COL_W-1:0] end_c_q, end_c_d;
  logic [ROW_W-1:0] cnt_q, cnt_d;
  logic             mv_r_q, mv_r_d, up_r_q, up_r_d;
  logic             mv_c_q, mv_c_d, up_c_q, up_c_d;
  logic             horiz_q, horiz_d;
  logic [WORD_W-1:0] word_q, word_d;

  // Output register.
  logic              out_valid_q;
  logic [WORD_W-1:0] out_bits_q;
  logic              out_err_q;
  logic [CNT_W-1:0]  out_line_q, out_point_q;
  logic              out_load;

  // Grid memory, with one valid bit per row so reset and clear take effect at once.
  logic [MAX_COLS-1:0] mem_q [MAX_ROWS];
  logic [MAX_ROWS-1:0] valid_q;
  logic [MAX_COLS-1:0] rd_data_q;
  logic                rd_valid_q;
  logic                mem_re, mem_we, clear_all;
  logic [MAX_COLS-1:0] mem_wdata, base_word, mask;

  // Point check and segment geometry, evaluated in the execute state.
  logic                      row_ok, col_ok, pt_ok, rd_in_range, seg_ok;
  logic [ROW_W-1:0]          new_r;
  logic [COL_W-1:0]          new_c;
  logic signed [DLT_W-1:0]   dr, dc;
  logic [DLT_W-1:0]          ar, ac;
  logic [CNT_W-1:0]          line_inc, point_inc;

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    row_ok = (row_q >= 0) && (row_q < $signed({9'd0, cfg_rows_q})) &&
             (row_q < $signed(COORD_W'(MAX_ROWS)));
    col_ok = (col_q >= 0) && (col_q < $signed({9'd0, cfg_cols_q})) &&
             (col_q < $signed(COORD_W'(MAX_COLS)));
    pt_ok  = row_ok && col_ok;
    rd_in_range = (row_q >= 0) && (row_q < $signed(COORD_W'(MAX_ROWS)));
    new_r = row_q[ROW_W-1:0];
    new_c = col_q[COL_W-1:0];
    dr = $signed({1'b0, IDX_W'(new_r)}) - $signed({1'b0, IDX_W'(last_r_q)});
    dc = $signed({1'b0, IDX_W'(new_c)}) - $signed({1'b0, IDX_W'(last_c_q)});
    ar = dr[DLT_W-1] ? DLT_W'(-dr) : DLT_W'(dr);
    ac = dc[DLT_W-1] ? DLT_W'(-dc) : DLT_W'(dc);
    seg_ok = (dr == '0) || (dc == '0) || (ar == ac);
    line_inc  = (line_q  != {CNT_W{1'b1}}) ? line_q  + 1'b1 : line_q;
    point_inc = (point_q != {CNT_W{1'b1}}) ? point_q + 1'b1 : point_q;
  end

  // A horizontal run is marked in one write as a range of columns.
  always_comb begin
    base_word = rd_valid_q ? rd_data_q : '0;
    if (horiz_q) begin
      mask = ({MAX_COLS{1'b1}} << cur_c_q) &
             ({MAX_COLS{1'b1}} >> (COL_W'(MAX_COLS - 1) - end_c_q));
    end else begin
      mask = {{(MAX_COLS-1){1'b0}}, 1'b1} << cur_c_q;
    end
    mem_wdata = base_word | mask;
  end

  always_comb begin
    state_d  = state_q;
    last_r_d = last_r_q;
    last_c_d = last_c_q;
    line_d   = line_q;
    point_d  = point_q;
    fault_d  = fault_q;
    fline_d  = fline_q;
    fpoint_d = fpoint_q;
    cur_r_d  = cur_r_q;
    cur_c_d  = cur_c_q;
    end_c_d  = end_c_q;
    cnt_d    = cnt_q;
    mv_r_d   = mv_r_q;
    up_r_d   = up_r_q;
    mv_c_d   = mv_c_q;
    up_c_d   = up_c_q;
    horiz_d  = horiz_q;
    word_d   = word_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    clear_all = 1'b0;
    out_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        word_d  = '0;
        state_d = ST_DONE;
        unique case (op_q)
          OP_START: begin
            if (!fault_q) begin
              line_d  = line_inc;
              point_d = CNT_W'(1);
              if (!pt_ok) begin
                fault_d  = 1'b1;
                fline_d  = line_inc;
                fpoint_d = CNT_W'(1);
              end else begin
                last_r_d = new_r;
                last_c_d = new_c;
              end
            end
          end
          OP_NEXT: begin
            if (!fault_q) begin
              point_d = point_inc;
              if (!pt_ok || !seg_ok) begin
                fault_d  = 1'b1;
                fline_d  = line_q;
                fpoint_d = point_inc;
              end else begin
                // The walk starts at the previous point; the new point becomes
                // the start of the following segment.
                last_r_d = new_r;
                last_c_d = new_c;
                cur_r_d  = last_r_q;
                horiz_d  = (dr == '0);
                mv_r_d   = (dr != '0);
                up_r_d   = !dr[DLT_W-1];
                mv_c_d   = (dc != '0);
                up_c_d   = !dc[DLT_W-1];
                if (dr == '0) begin
                  cur_c_d = dc[DLT_W-1] ? new_c : last_c_q;
                  end_c_d = dc[DLT_W-1] ? last_c_q : new_c;
                  cnt_d   = '0;
                end else begin
                  cur_c_d = last_c_q;
                  end_c_d = last_c_q;
                  cnt_d   = ar[ROW_W-1:0];
                end
                state_d = ST_RD;
              end
            end
          end
          OP_READ: begin
            if (rd_in_range) begin
              cur_r_d = new_r;
              state_d = ST_RD;
            end
          end
          OP_CLEAR: begin
            clear_all = 1'b1;
            last_r_d  = '0;
            last_c_d  = '0;
            line_d    = '0;
            point_d   = '0;
            fault_d   = 1'b0;
            fline_d   = '0;
            fpoint_d  = '0;
          end
          default: ;
        endcase
      end

      ST_RD: begin
        mem_re  = 1'b1;
        state_d = (op_q == OP_READ) ? ST_RDOUT : ST_WR;
      end

      ST_WR: begin
        mem_we = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
          if (mv_r_q) begin
            cur_r_d = up_r_q ? cur_r_q + 1'b1 : cur_r_q - 1'b1;
          end
          if (mv_c_q) begin
            cur_c_d = up_c_q ? cur_c_q + 1'b1 : cur_c_q - 1'b1;
          end
          state_d = ST_RD;
        end
      end

      ST_RDOUT: begin
        word_d  = WORD_W'(base_word);
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cfg_rows_q <= CFG_W'(64);
      cfg_cols_q <= CFG_W'(64);
      last_r_q   <= '0;
      last_c_q   <= '0;
      line_q     <= '0;
      point_q    <= '0;
      fault_q    <= 1'b0;
      fline_q    <= '0;
      fpoint_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      last_r_q <= last_r_d;
      last_c_q <= last_c_d;
      line_q   <= line_d;
      point_q  <= point_d;
      fault_q  <= fault_d;
      fline_q  <= fline_d;
      fpoint_q <= fpoint_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_ROWS: cfg_rows_q <= cfg_data_i;
          CFG_COLS: cfg_cols_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_i.valid) begin
      op_q  <= opcode_e'(in_i.opcode);
      row_q <= in_i.point_row;
      col_q <= in_i.point_col;
    end
    cur_r_q <= cur_r_d;
    cur_c_q <= cur_c_d;
    end_c_q <= end_c_d;
    cnt_q   <= cnt_d;
    mv_r_q  <= mv_r_d;
    up_r_q  <= up_r_d;
    mv_c_q  <= mv_c_d;
    up_c_q  <= up_c_d;
    horiz_q <= horiz_d;
    word_q  <= word_d;
    if (out_load) begin
      out_bits_q  <= word_q;
      out_err_q   <= fault_q;
      out_line_q  <= fline_q;
      out_point_q <= fpoint_q;
    end
  end

  // Grid memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cur_r_q] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[cur_r_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (clear_all) begin
        valid_q <= '0;
      end else if (mem_we) begin
        valid_q[cur_r_q] <= 1'b1;
      end
      if (mem_re) begin
        rd_valid_q <= valid_q[cur_r_q];
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.row_bits    = out_bits_q;
  assign out_o.error_seen  = out_err_q;
  assign out_o.error_line  = out_line_q;
  assign out_o.error_point = out_point_q;

  // The error flag is raised only while a command is executed.
  a_fault_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fault_q) |-> $past(state_q) == ST_EXEC)
    else $error("error flag set outside command execution");

  // The last row marked by a segment walk is the row of the new point.
  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR && cnt_q == '0) |-> (cur_r_q == last_r_q))
    else $error("segment walk did not end on the new point's row");

  // A transaction on the command side always moves the sequencer into execute.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == ST_EXEC))
    else $error("accepted command was not executed");

  // A finished result never overwrites one that is still waiting.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !out_load)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

/* verif/opp_plot_checker.sv */
`timescale 1ns / 100ps
// Result checker for the octilinear polyline plotter: keeps its own grid, counters
// and error record, predicts each result and compares it with the result channel.
// Depends on opp_pkg and on the opp_in_if and opp_out_if channel interfaces.
module opp_plot_checker import opp_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [CFG_W-1:0]     cfg_data_i,
  opp_in_if                   cmd_mon,
  opp_out_if                  res_mon,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [WORD_W-1:0] row_bits;
    logic              error_seen;
    logic [CNT_W-1:0]  error_line;
    logic [CNT_W-1:0]  error_point;
  } plot_result_t;

  logic [WORD_W-1:0] grid_q [MAX_ROWS];
  logic [ROW_W-1:0]  last_row;
  logic [COL_W-1:0]  last_col;
  logic [CNT_W-1:0]  line_cnt;
  logic [CNT_W-1:0]  point_cnt;
  logic              fault_seen;
  logic [CNT_W-1:0]  fault_line;
  logic [CNT_W-1:0]  fault_point;
  logic [CFG_W-1:0]  rows_lim;
  logic [CFG_W-1:0]  cols_lim;

  plot_result_t      plot_results_q [$];
  plot_result_t      want;
  plot_result_t      seen;
  plot_result_t      fresh;

  function automatic bit point_valid(input int r, input int c);
    return r >= 0 && r < int'(rows_lim) && r < MAX_ROWS &&
           c >= 0 && c < int'(cols_lim) && c < MAX_COLS;
  endfunction

  task automatic clear_plot();
    for (int i = 0; i < MAX_ROWS; i++) grid_q[i] = '0;
    last_row    = '0;
    last_col    = '0;
    line_cnt    = '0;
    point_cnt   = '0;
    fault_seen  = 1'b0;
    fault_line  = '0;
    fault_point = '0;
  endtask

  task automatic raise_fault();
    fault_seen  = 1'b1;
    fault_line  = line_cnt;
    fault_point = point_cnt;
  endtask

  task automatic plot_item(input opcode_e op, input int c, input int r,
                           output plot_result_t res);
    int pr, pc, dr, dc, step_r, step_c, span, k;
    res = '0;
    case (op)
      OP_START: begin
        if (!fault_seen) begin
          if (line_cnt != '1) line_cnt++;
          point_cnt = 1;
          if (point_valid(r, c)) begin
            last_row = r[ROW_W-1:0];
            last_col = c[COL_W-1:0];
          end else begin
            raise_fault();
          end
        end
      end
      OP_NEXT: begin
        if (!fault_seen) begin
          if (point_cnt != '1) point_cnt++;
          pr = int'(last_row);
          pc = int'(last_col);
          dr = r - pr;
          dc = c - pc;
          if (!point_valid(r, c)) begin
            raise_fault();
          end else if (dr == 0 || dc == 0 || dr == dc || dr == -dc) begin
            step_r = (dr > 0) ? 1 : ((dr < 0) ? -1 : 0);
            step_c = (dc > 0) ? 1 : ((dc < 0) ? -1 : 0);
            span   = (dr < 0) ? -dr : dr;
            if (((dc < 0) ? -dc : dc) > span) span = (dc < 0) ? -dc : dc;
            for (k = 0; k <= span; k++) grid_q[pr + step_r * k][pc + step_c * k] = 1'b1;
            last_row = r[ROW_W-1:0];
            last_col = c[COL_W-1:0];
          end else begin
            raise_fault();
          end
        end
      end
      OP_READ: begin
        if (r >= 0 && r < MAX_ROWS) res.row_bits = grid_q[r];
      end
      default: clear_plot();
    endcase
    res.error_seen  = fault_seen;
    res.error_line  = fault_line;
    res.error_point = fault_point;
  endtask

  // Result side is handled before the command side, so a result accepted on the
  // same edge as a new command is matched against the older expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_plot();
      rows_lim = CFG_W'(MAX_ROWS);
      cols_lim = CFG_W'(MAX_COLS);
      plot_results_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ROWS: rows_lim = cfg_data_i;
          default:  cols_lim = cfg_data_i;
        endcase
      end
      if (res_mon.valid && res_mon.ready) begin
        seen = {res_mon.row_bits, res_mon.error_seen, res_mon.error_line,
                res_mon.error_point};
        if (plot_results_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected result row_bits=%h error=%b line=%0d point=%0d",
                     $time, seen.row_bits, seen.error_seen, seen.error_line,
                     seen.error_point);
        end else begin
          want = plot_results_q.pop_front();
          if (seen.row_bits !== want.row_bits || seen.error_seen !== want.error_seen ||
              seen.error_line !== want.error_line ||
              seen.error_point !== want.error_point) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: expected row_bits=%h error=%b line=%0d point=%0d, got %s",
                       $time, want.row_bits, want.error_seen, want.error_line,
                       want.error_point,
                       $sformatf("row_bits=%h error=%b line=%0d point=%0d",
                                 seen.row_bits, seen.error_seen, seen.error_line,
                                 seen.error_point));
          end
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        plot_item(opcode_e'(cmd_mon.opcode), int'(cmd_mon.point_col),
                  int'(cmd_mon.point_row), fresh);
        plot_results_q.push_back(fresh);
      end
      pending_o = plot_results_q.size();
    end
  end

endmodule

/* verif/octilinear_polyline_plotter_tb.sv */
`timescale 1ns / 100ps
// Top of the octilinear polyline plotter testbench: clock, reset, command stimulus,
// result stalls and the verdict. Depends on opp_pkg, both channel interfaces,
// the plotter itself and the opp_plot_checker module.
module octilinear_polyline_plotter_tb;
  import opp_pkg::*;

  // Grid settings visited by the random phases. Zero, one, the maximum and values
  // above the maximum all appear; the last phase runs without any idling.
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 190;
  localparam int ROWS_SET [PHASES] = '{64, 1, 0, 50, 127, 23, 65, 64};
  localparam int COLS_SET [PHASES] = '{64, 1, 37, 0, 100, 64, 9, 64};

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  int fail_count;
  int pending;

  // Stimulus-side view of the grid extent, used only to shape the random
  // polylines so that most of them stay on the grid.
  int rows_span;
  int cols_span;
  int sent_cnt;
  bit idle_on;
  bit chain_broken;

  opp_in_if  cmd_if ();
  opp_out_if res_if ();

  octilinear_polyline_plotter i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (cmd_if),
    .out_o      (res_if)
  );

  opp_plot_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .cmd_mon      (cmd_if),
    .res_mon      (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // About 1600 transactions, each at most a full-height segment plus the longest
  // gap and stall, fit in this bound with a wide margin.
  initial begin
    #30_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Result side: ready drops in random bursts while idling is
  // enabled, and otherwise stays high.
  initial begin : result_stalls
    int stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        res_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 17);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Presents one command transaction and returns on the edge that accepts it.
  // valid is left high so that a following command goes out back to back; any
  // caller that stops sending lowers it in the same time step.
  task automatic send_item(input opcode_e op, input int col, input int row);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.opcode    <= op;
    cmd_if.point_col <= 16'(col);
    cmd_if.point_row <= 16'(row);
    do @(posedge clk); while (!cmd_if.ready);
    sent_cnt++;
  endtask

  // Stops sending and waits until every predicted result has been taken, then
  // waits on so that the plotter is back in its idle state.
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both size registers on consecutive edges, with the block idle.
  task automatic set_grid(input int rows, input int cols);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_ROWS;
    cfg_data <= CFG_W'(rows);
    @(posedge clk);
    cfg_idx  <= CFG_COLS;
    cfg_data <= CFG_W'(cols);
    @(posedge clk);
    cfg_we   <= 1'b0;
    rows_span = (rows > MAX_ROWS) ? MAX_ROWS : rows;
    cols_span = (cols > MAX_COLS) ? MAX_COLS : cols;
  endtask

  // One random polyline: mostly legal octilinear segments with random lengths,
  // sometimes a point off the grid or at an arbitrary angle, with reads mixed in
  // and an occasional burst of completely random commands.
  task automatic plot_random_polyline();
    int r, c, nr, nc, dr, dc, reach, len, k, segs, pick;
    // An error blocks all drawing until a clear, so clear after any breakage.
    if (chain_broken || $urandom_range(0, 4) == 0) begin
      send_item(OP_CLEAR, $urandom, $urandom);
      chain_broken = 1'b0;
    end
    if (rows_span == 0 || cols_span == 0) begin
      // With an empty row or column range every point is refused.
      send_item(opcode_e'($urandom_range(0, 1)), $urandom_range(0, MAX_COLS - 1),
                $urandom_range(0, MAX_ROWS - 1));
      chain_broken = 1'b1;
    end else begin
      r = $urandom_range(0, rows_span - 1);
      c = $urandom_range(0, cols_span - 1);
      send_item(OP_START, c, r);
      segs = $urandom_range(1, 8);
      for (k = 0; k < segs && !chain_broken; k++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          // Step off the grid on one side, or jump anywhere in the field range.
          nr = r;
          nc = c;
          case ($urandom_range(0, 4))
            0: nr = rows_span;
            1: nc = cols_span;
            2: nr = -1;
            3: nc = -1;
            default: begin
              nr = $urandom;
              nc = $urandom;
            end
          endcase
          send_item(OP_NEXT, nc, nr);
          chain_broken = 1'b1;
          // Starts after an error must be ignored.
          if ($urandom_range(0, 2) == 0) send_item(OP_START, c, r);
        end else if (pick == 1) begin
          // Any point on the grid; usually at an angle that is not allowed.
          send_item(OP_NEXT, $urandom_range(0, cols_span - 1),
                    $urandom_range(0, rows_span - 1));
          chain_broken = 1'b1;
        end else if (pick == 2) begin
          send_item(OP_READ, $urandom, $urandom_range(0, MAX_ROWS - 1));
        end else begin
          dr = int'($urandom_range(0, 2)) - 1;
          dc = int'($urandom_range(0, 2)) - 1;
          reach = MAX_ROWS;
          if (dr > 0 && rows_span - 1 - r < reach) reach = rows_span - 1 - r;
          if (dr < 0 && r < reach) reach = r;
          if (dc > 0 && cols_span - 1 - c < reach) reach = cols_span - 1 - c;
          if (dc < 0 && c < reach) reach = c;
          if (dr == 0 && dc == 0) reach = 0;
          // Short segments keep the run fast; a quarter may span the whole grid.
          if ($urandom_range(0, 3) == 0) len = $urandom_range(0, reach);
          else len = $urandom_range(0, (reach < 6) ? reach : 6);
          nr = r + dr * len;
          nc = c + dc * len;
          send_item(OP_NEXT, nc, nr);
          r = nr;
          c = nc;
        end
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3))
        send_item(opcode_e'($urandom_range(0, 3)), $urandom, $urandom);
      chain_broken = 1'b1;
    end
    repeat ($urandom_range(1, 2))
      send_item(OP_READ, $urandom,
                ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, MAX_ROWS - 1));
  endtask

  initial begin : stimulus
    int p, k, phase_goal;
    cmd_if.valid     <= 1'b0;
    cmd_if.opcode    <= OP_START;
    cmd_if.point_col <= '0;
    cmd_if.point_row <= '0;
    cfg_we           <= 1'b0;
    cfg_idx          <= CFG_ROWS;
    cfg_data         <= '0;
    rst_n            = 1'b0;
    idle_on          = 1'b1;
    chain_broken     = 1'b0;
    sent_cnt         = 0;
    rows_span        = MAX_ROWS;
    cols_span        = MAX_COLS;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, on the reset grid of 64 by 64.
    send_item(OP_READ, 0, 0);
    // A segment before any start continues from the origin as polyline zero.
    send_item(OP_NEXT, 5, 0);
    send_item(OP_START, 10, 10);
    send_item(OP_NEXT, 20, 10);
    send_item(OP_NEXT, 20, 20);
    send_item(OP_NEXT, 15, 25);
    // A repeated point marks a single cell.
    send_item(OP_NEXT, 15, 25);
    // Corner to corner along the anti-diagonal.
    send_item(OP_START, 63, 0);
    send_item(OP_NEXT, 0, 63);
    send_item(OP_READ, 0, 25);
    send_item(OP_READ, 0, 63);
    // Reads outside the grid return an empty word.
    send_item(OP_READ, 0, -1);
    send_item(OP_READ, 0, 64);
    send_item(OP_READ, -32768, -32768);
    send_item(OP_READ, 32767, 32767);
    // A segment at an angle that is not a multiple of 45 degrees sets the error,
    // after which starts and segments are dropped but reads still work.
    send_item(OP_NEXT, 2, 62);
    send_item(OP_START, 5, 5);
    send_item(OP_NEXT, 6, 5);
    send_item(OP_READ, 0, 5);
    send_item(OP_CLEAR, 0, 0);
    send_item(OP_READ, 0, 10);
    // Points at the extremes of the coordinate fields, and one just past the last row, are off the grid.
    send_item(OP_START, -32768, 5);
    send_item(OP_CLEAR, 0, 0);
    send_item(OP_START, 5, 32767);
    send_item(OP_CLEAR, 0, 0);
    send_item(OP_NEXT, 0, 64);
    chain_broken = 1'b1;

    // Random phases. Each one changes the grid size while a polyline may still be
    // open, so its first segment continues from the point stored before.
    for (p = 0; p < PHASES; p++) begin
      set_grid(ROWS_SET[p], COLS_SET[p]);
      if (p == PHASES - 1) begin
        idle_on = 1'b0;
        // Both counters are run up past one and then captured in the error
        // record by a point off the grid.
        send_item(OP_CLEAR, 0, 0);
        for (k = 0; k < 6; k++) send_item(OP_START, 3, 3);
        send_item(OP_START, -1, 0);
        send_item(OP_CLEAR, 0, 0);
        send_item(OP_START, 7, 7);
        for (k = 0; k < 6; k++) send_item(OP_NEXT, 7, 7);
        send_item(OP_NEXT, 0, -1);
        send_item(OP_READ, 0, 7);
        chain_broken = 1'b1;
      end else if (rows_span > 0 && cols_span > 0 && !chain_broken) begin
        send_item(OP_NEXT, $urandom_range(0, cols_span - 1),
                  $urandom_range(0, rows_span - 1));
        chain_broken = 1'b1;
      end
      phase_goal = sent_cnt + PHASE_ITEMS;
      while (sent_cnt < phase_goal) plot_random_polyline();
    end

    drain_results();
    repeat (150) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
